### rtl/lqet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqet_pkg
// Shared types, codes and fixed-point helpers of the link-quality table.
// ----------------------------------------------------------------------------
package lqet_pkg;

    localparam int          ADDR_W      = 48;
    localparam int          SEQ_W       = 16;
    localparam int          TIME_W      = 32;
    localparam int          EST_W       = 32;
    localparam int          STATUS_W    = 2;
    localparam int          INDEX_W     = 4;
    localparam int          TRUST_W     = 17;
    localparam int          PROD_W      = 51;

    localparam logic [EST_W-1:0]     ONE_Q16      = 32'h0001_0000;
    localparam logic [63:0]          EXP_STEP_Q32 = 64'd4206414439;

    localparam logic [STATUS_W-1:0]  STATUS_UPDATE = 2'd0;
    localparam logic [STATUS_W-1:0]  STATUS_NEW    = 2'd1;
    localparam logic [STATUS_W-1:0]  STATUS_FULL   = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [SEQ_W-1:0]   seq;
        logic [TIME_W-1:0]  stamp;
        logic [EST_W-1:0]   alpha;
        logic [EST_W-1:0]   beta;
    } entry_t;

    // Signed distance from 1.0 of an estimate
    function automatic logic signed [32:0] excess(input logic [EST_W-1:0] v);
        excess = $signed({1'b0, v}) - $signed({1'b0, ONE_Q16});
    endfunction

    // Round the scaled excess, add back 1.0, clamp to the unsigned range
    function automatic logic [EST_W-1:0] decay_finish(input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W:0] q;
        logic signed [35:0]     r;
        logic signed [36:0]     s;
        q = 52'(prod) + 52'sh8000;
        r = 36'(q >>> 16);
        s = 37'(r) + 37'sh1_0000;
        if (s < 0)
            decay_finish = '0;
        else if (s > 37'sh0_FFFF_FFFF)
            decay_finish = '1;
        else
            decay_finish = s[EST_W-1:0];
    endfunction

endpackage

### rtl/lqet_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqet_if
// Request, response and configuration channels of the link-quality table.
// ----------------------------------------------------------------------------
interface lqet_req_if;
    logic                          valid;
    logic                          ready;
    logic [lqet_pkg::ADDR_W-1:0]   station_addr;
    logic [lqet_pkg::SEQ_W-1:0]    seq_num;
    logic [lqet_pkg::TIME_W-1:0]   time_ticks;

    modport source (output valid, station_addr, seq_num, time_ticks, input ready);
    modport sink   (input valid, station_addr, seq_num, time_ticks, output ready);
endinterface

interface lqet_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [lqet_pkg::STATUS_W-1:0]   status;
    logic [lqet_pkg::INDEX_W-1:0]    entry_index;
    logic [lqet_pkg::SEQ_W-1:0]      seq_gap;
    logic [lqet_pkg::EST_W-1:0]      alpha_est;
    logic [lqet_pkg::EST_W-1:0]      beta_est;

    modport source (output valid, status, entry_index, seq_gap, alpha_est, beta_est,
                    input ready);
    modport sink   (input valid, status, entry_index, seq_gap, alpha_est, beta_est,
                    output ready);
endinterface

interface lqet_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lqet_pkg::ADDR_W-1:0]   own_address;

    modport source (output valid, own_address, input ready);
    modport sink   (input valid, own_address, output ready);
endinterface

### rtl/link_quality_estimator_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_quality_estimator_table_unit
// Per-station link-quality table with decaying alpha/beta estimates.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  --------+-----------+-----------------------------------------------------
//  req     | in        | station_addr, seq_num, time_ticks
//  rsp     | out       | status, entry_index, seq_gap, alpha_est, beta_est
//  cfg     | in        | own_address
//
//  A request for a new station scans all stored entries, then outputs; one for a
//  known station stops its scan at the hit: the table memory is scanned one
//  entry a cycle, then one shared multiplier decays alpha and beta in turn.
//  A request from own_address is accepted and dropped with no response.
//  Reset clears the entry count, so the table starts empty without a sweep.
//  A stalled response holds in the output register; the next request runs up
//  to its own output step and holds there until the register frees or is
//  replaced on the same edge.
// ----------------------------------------------------------------------------
module link_quality_estimator_table_unit #(
    parameter int TABLE_DEPTH      = 16,
    parameter int TRUST_TABLE_SIZE = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    lqet_req_if.sink     req,
    lqet_rsp_if.source   rsp,
    lqet_cfg_if.sink     cfg
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = (TRUST_TABLE_SIZE > 1) ? $clog2(TRUST_TABLE_SIZE) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_MUL_A  = 3'd2;
    localparam logic [2:0] S_MUL_B  = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    typedef logic [lqet_pkg::TRUST_W-1:0] trust_rom_t [TRUST_TABLE_SIZE];

    function automatic trust_rom_t build_trust();
        trust_rom_t  t;
        logic [63:0] p;
        p = 64'h1_0000_0000;
        for (int i = 0; i < TRUST_TABLE_SIZE; i++)
        begin
            t[i] = lqet_pkg::TRUST_W'((p + 64'h8000) >> 16);
            p    = (p * lqet_pkg::EXP_STEP_Q32 + 64'h8000_0000) >> 32;
        end
        return t;
    endfunction

    localparam trust_rom_t TRUST_ROM = build_trust();

    // state and control
    logic [2:0]                      state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   scan_reg, scan_next;
    logic                            pend_reg, pend_next;
    logic [IW-1:0]                   slot_reg, slot_next;
    logic [lqet_pkg::ADDR_W-1:0]     own_reg;

    // request and working registers
    logic [lqet_pkg::ADDR_W-1:0]     addr_reg;
    logic [lqet_pkg::SEQ_W-1:0]      seq_reg;
    logic [lqet_pkg::TIME_W-1:0]     time_reg;
    logic [lqet_pkg::SEQ_W-1:0]      gap_reg;
    logic [lqet_pkg::TRUST_W-1:0]    trust_reg;
    logic signed [lqet_pkg::PROD_W-1:0] prod_reg;
    logic [lqet_pkg::EST_W-1:0]      alpha_reg;

    // pending response
    logic [lqet_pkg::STATUS_W-1:0]   res_status_reg;
    logic [lqet_pkg::INDEX_W-1:0]    res_index_reg;
    logic [lqet_pkg::SEQ_W-1:0]      res_gap_reg;
    logic [lqet_pkg::EST_W-1:0]      res_alpha_reg;
    logic [lqet_pkg::EST_W-1:0]      res_beta_reg;

    // output register
    logic                            out_valid_reg;
    logic [lqet_pkg::STATUS_W-1:0]   out_status_reg;
    logic [lqet_pkg::INDEX_W-1:0]    out_index_reg;
    logic [lqet_pkg::SEQ_W-1:0]      out_gap_reg;
    logic [lqet_pkg::EST_W-1:0]      out_alpha_reg;
    logic [lqet_pkg::EST_W-1:0]      out_beta_reg;

    // table memory
    lqet_pkg::entry_t                mem [TABLE_DEPTH];
    lqet_pkg::entry_t                mem_q;
    logic                            rd_en;
    logic [IW-1:0]                   rd_addr;
    logic                            wr_en;
    logic [IW-1:0]                   wr_addr;
    lqet_pkg::entry_t                wr_data;

    logic                            req_fire;
    logic                            hit;
    logic                            scan_more;
    logic                            miss;
    logic                            load_out;
    logic [lqet_pkg::TIME_W-1:0]     dt;
    logic                            dt_in_range;
    logic [lqet_pkg::EST_W-1:0]      mul_operand;
    logic signed [lqet_pkg::PROD_W-1:0] mul_result;
    logic [lqet_pkg::EST_W-1:0]      alpha_decay;
    logic [32:0]                     alpha_sum;
    logic [lqet_pkg::EST_W-1:0]      alpha_new;
    logic [lqet_pkg::EST_W-1:0]      beta_decay;
    logic signed [34:0]              beta_sum;
    logic [lqet_pkg::EST_W-1:0]      beta_new;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;

    assign hit       = (state_reg == S_SEARCH) && pend_reg && (mem_q.addr == addr_reg);
    assign scan_more = (scan_reg < count_reg);
    assign miss      = (state_reg == S_SEARCH) && !hit && !scan_more;
    assign rd_en     = (state_reg == S_SEARCH) && !hit && scan_more;
    assign rd_addr   = scan_reg[IW-1:0];
    assign load_out  = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);

    assign dt          = time_reg - mem_q.stamp;
    assign dt_in_range = (dt < lqet_pkg::TIME_W'(TRUST_TABLE_SIZE));

    // shared multiplier: alpha first, then beta
    assign mul_operand = (state_reg == S_MUL_A) ? mem_q.alpha : mem_q.beta;
    assign mul_result  = lqet_pkg::PROD_W'(lqet_pkg::excess(mul_operand)
                         * $signed({1'b0, trust_reg}));

    assign alpha_decay = lqet_pkg::decay_finish(prod_reg);
    assign alpha_sum   = {1'b0, alpha_decay} + {1'b0, lqet_pkg::ONE_Q16};
    assign alpha_new   = alpha_sum[32] ? '1 : alpha_sum[31:0];

    assign beta_decay  = lqet_pkg::decay_finish(prod_reg);
    assign beta_sum    = $signed({3'b000, beta_decay}) + $signed({3'b000, gap_reg, 16'h0000})
                         - $signed({3'b000, lqet_pkg::ONE_Q16});
    assign beta_new    = (beta_sum < 0) ? '0
                       : ((beta_sum > 35'sh0_FFFF_FFFF) ? '1 : beta_sum[31:0]);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IW-1:0];
        wr_data = '{addr: addr_reg, seq: seq_reg, stamp: time_reg,
                    alpha: lqet_pkg::ONE_Q16, beta: lqet_pkg::ONE_Q16};
        if (miss && (count_reg != CW'(TABLE_DEPTH)))
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == S_FIN)
        begin
            wr_en         = 1'b1;
            wr_addr       = slot_reg;
            wr_data.alpha = alpha_reg;
            wr_data.beta  = beta_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            mem_q <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        pend_next  = pend_reg;
        slot_next  = slot_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.station_addr != own_reg))
                begin
                    state_next = S_SEARCH;
                    scan_next  = '0;
                    pend_next  = 1'b0;
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    slot_next  = IW'(scan_reg - CW'(1));
                    state_next = S_MUL_A;
                end
                else if (scan_more)
                begin
                    scan_next = scan_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    if (count_reg != CW'(TABLE_DEPTH))
                        count_next = count_reg + CW'(1);
                    state_next = S_OUT;
                end
            end
            S_MUL_A: state_next = S_MUL_B;
            S_MUL_B: state_next = S_FIN;
            S_FIN:   state_next = S_OUT;
            S_OUT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            slot_reg      <= '0;
            own_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            slot_reg  <= slot_next;
            if (cfg.valid && cfg.ready)
                own_reg <= cfg.own_address;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            addr_reg <= req.station_addr;
            seq_reg  <= req.seq_num;
            time_reg <= req.time_ticks;
        end
        if (hit)
        begin
            gap_reg   <= seq_reg - mem_q.seq;
            trust_reg <= dt_in_range ? TRUST_ROM[dt[TW-1:0]] : '0;
        end
        if ((state_reg == S_MUL_A) || (state_reg == S_MUL_B))
            prod_reg <= mul_result;
        if (state_reg == S_MUL_B)
            alpha_reg <= alpha_new;
        if (miss)
        begin
            res_gap_reg <= '0;
            if (count_reg == CW'(TABLE_DEPTH))
            begin
                res_status_reg <= lqet_pkg::STATUS_FULL;
                res_index_reg  <= '0;
                res_alpha_reg  <= '0;
                res_beta_reg   <= '0;
            end
            else
            begin
                res_status_reg <= lqet_pkg::STATUS_NEW;
                res_index_reg  <= lqet_pkg::INDEX_W'(count_reg);
                res_alpha_reg  <= lqet_pkg::ONE_Q16;
                res_beta_reg   <= lqet_pkg::ONE_Q16;
            end
        end
        if (state_reg == S_FIN)
        begin
            res_status_reg <= lqet_pkg::STATUS_UPDATE;
            res_index_reg  <= lqet_pkg::INDEX_W'(slot_reg);
            res_gap_reg    <= gap_reg;
            res_alpha_reg  <= alpha_reg;
            res_beta_reg   <= beta_new;
        end
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_gap_reg    <= res_gap_reg;
            out_alpha_reg  <= res_alpha_reg;
            out_beta_reg   <= res_beta_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_index = out_index_reg;
    assign rsp.seq_gap     = out_gap_reg;
    assign rsp.alpha_est   = out_alpha_reg;
    assign rsp.beta_est    = out_beta_reg;

endmodule

### rtl/lqet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqet_checker
// Port-level checks of the link-quality table, bound to the top level.
// ----------------------------------------------------------------------------
module lqet_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  logic [lqet_pkg::STATUS_W-1:0]   rsp_status,
    input  logic [lqet_pkg::INDEX_W-1:0]    rsp_entry_index,
    input  logic [lqet_pkg::SEQ_W-1:0]      rsp_seq_gap,
    input  logic [lqet_pkg::EST_W-1:0]      rsp_alpha_est,
    input  logic [lqet_pkg::EST_W-1:0]      rsp_beta_est
);

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_alpha_est) && $stable(rsp_beta_est))
        else $error("stalled response changed");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == lqet_pkg::STATUS_FULL) |->
            (rsp_entry_index == '0) && (rsp_seq_gap == '0)
            && (rsp_alpha_est == '0) && (rsp_beta_est == '0))
        else $error("table-full response carries data");

    a_new_init: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == lqet_pkg::STATUS_NEW) |->
            (rsp_seq_gap == '0) && (rsp_alpha_est == lqet_pkg::ONE_Q16)
            && (rsp_beta_est == lqet_pkg::ONE_Q16))
        else $error("new entry not initialized to one");

    a_alpha_floor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == lqet_pkg::STATUS_UPDATE) |->
            (rsp_alpha_est >= 32'h0002_0000))
        else $error("updated alpha below two");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == lqet_pkg::STATUS_UPDATE)
            || (rsp_status == lqet_pkg::STATUS_NEW)
            || (rsp_status == lqet_pkg::STATUS_FULL))
        else $error("undefined status code");

endmodule

bind link_quality_estimator_table_unit lqet_checker u_lqet_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_entry_index (rsp.entry_index),
    .rsp_seq_gap     (rsp.seq_gap),
    .rsp_alpha_est   (rsp.alpha_est),
    .rsp_beta_est    (rsp.beta_est)
);
